>>> src/alfg_pkg.sv
// Package for the additive lagged-Fibonacci generator.
// Table geometry, seeding constants, command codes, index helpers, sequencer states and the fill write bus.
// No dependencies.
package alfg_pkg;

    localparam int TABLE_DEPTH = 55;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam logic [IDX_W-1:0] TOP_INDEX   = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W-1:0] SHORT_START = IDX_W'(23);
    localparam logic [IDX_W-1:0] LONG_START  = IDX_W'(54);

    localparam logic [31:0] LCG_MUL    = 32'd69069;
    localparam logic [31:0] LCG_ADD    = 32'd1725307361;
    localparam logic [31:0] RESET_SEED = 32'd1;

    // command carried on s_tuser
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_ADD
    } state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } fill_wr_t;

    // out-of-range index (never reached) is taken as the top entry
    function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W-1:0] ix);
        if (ix == '0 || ix > TOP_INDEX) begin
            return TOP_INDEX;
        end
        return ix;
    endfunction

    // count down through TOP_INDEX..1 with wrap
    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] ix);
        if (ix <= IDX_W'(1)) begin
            return TOP_INDEX;
        end
        return ix - IDX_W'(1);
    endfunction

endpackage

>>> src/alfg_seed_gen.sv
// Seed expander: walks the whole table once, one entry a cycle, with the 69069 LCG.
// Runs a seed-1 pass straight out of reset. Depends on alfg_pkg.
module alfg_seed_gen (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       seed,
    output alfg_pkg::fill_wr_t wr,
    output logic              done
);

    logic [31:0]                s_reg, s_next;
    logic [alfg_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       active_reg, active_next;
    logic                       last;

    assign last = (idx_reg == alfg_pkg::TOP_INDEX);

    always_comb begin
        s_next      = s_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        if (start) begin
            s_next      = seed;
            idx_next    = '0;
            active_next = 1'b1;
        end else if (active_reg) begin
            s_next   = s_reg * alfg_pkg::LCG_MUL + alfg_pkg::LCG_ADD;
            idx_next = idx_reg + alfg_pkg::IDX_W'(1);
            if (last) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg      <= alfg_pkg::RESET_SEED;
            idx_reg    <= '0;
            active_reg <= 1'b1;
        end else begin
            s_reg      <= s_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

    assign wr.en   = active_reg;
    assign wr.addr = idx_reg;
    assign wr.data = s_reg + {16'd0, s_reg[31:16]};
    assign done    = active_reg && last;

endmodule

>>> src/additive_lagged_fibonacci_rng_top.sv
// Top level of the additive lagged-Fibonacci generator (lags 23 and 54).
// Holds the 55-word table, the two lag indices, the sequencer and the output register.
// Depends on alfg_pkg and alfg_seed_gen.
//
//  channel | ports              | payload
//  --------+--------------------+-------------------------------------------
//  input   | s_tvalid/s_tready  | s_tuser = cmd, s_tdata = seed
//  result  | m_tvalid/m_tready  | m_tdata[30:0] = value, bit 31 zero
//
// A draw runs through accept, table read (two read ports, registered),
// then add and write-back at the long index. In a reseed the seed expander
// writes one entry a cycle through the single write port.
// After reset the expander runs a seed-1 pass; s_tready is low.
// A finished value waits in the output register; a further draw may start,
// but holds in its add cycle until that value has been taken.
module additive_lagged_fibonacci_rng_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] value, [31] zero
);

    localparam int IW = alfg_pkg::IDX_W;

    alfg_pkg::state_t   state_reg, state_next;
    logic [IW-1:0]      short_idx_reg, short_idx_next;
    logic [IW-1:0]      long_idx_reg, long_idx_next;
    logic [IW-1:0]      j_idx, k_idx;
    logic               out_valid_reg, out_valid_next;
    logic [30:0]        value_reg, value_next;

    logic [31:0]        table_mem [alfg_pkg::TABLE_DEPTH];
    logic [31:0]        rd_j_reg, rd_k_reg;
    logic [31:0]        sum;

    logic               s_accept;
    logic               fill_start;
    logic               draw_write;
    logic               fill_done;
    alfg_pkg::fill_wr_t fill_wr;

    assign s_accept = s_tvalid && s_tready;
    assign j_idx    = alfg_pkg::clamp_index(short_idx_reg);
    assign k_idx    = alfg_pkg::clamp_index(long_idx_reg);
    assign sum      = rd_k_reg + rd_j_reg;

    alfg_seed_gen u_seed_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fill_start),
        .seed    (s_tdata),
        .wr      (fill_wr),
        .done    (fill_done)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            alfg_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == alfg_pkg::CMD_RESEED) ? alfg_pkg::S_FILL
                                                                    : alfg_pkg::S_READ;
                end
            end
            alfg_pkg::S_FILL: begin
                if (fill_done) begin
                    state_next = alfg_pkg::S_IDLE;
                end
            end
            alfg_pkg::S_READ: state_next = alfg_pkg::S_ADD;
            alfg_pkg::S_ADD: begin
                if (draw_write) begin
                    state_next = alfg_pkg::S_IDLE;
                end
            end
            default: state_next = alfg_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        fill_start = 1'b0;
        draw_write = 1'b0;
        case (state_reg)
            alfg_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                fill_start = s_tvalid && (s_tuser == alfg_pkg::CMD_RESEED);
            end
            alfg_pkg::S_ADD: begin
                // the add only completes once the output register has room
                draw_write = !out_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // indices and output register
    always_comb begin
        short_idx_next = short_idx_reg;
        long_idx_next  = long_idx_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (fill_start) begin
            short_idx_next = alfg_pkg::SHORT_START;
            long_idx_next  = alfg_pkg::LONG_START;
        end
        if (draw_write) begin
            short_idx_next = alfg_pkg::step_down(j_idx);
            long_idx_next  = alfg_pkg::step_down(k_idx);
            out_valid_next = 1'b1;
            value_next     = sum[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= alfg_pkg::S_FILL;
            short_idx_reg <= alfg_pkg::SHORT_START;
            long_idx_reg  <= alfg_pkg::LONG_START;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            short_idx_reg <= short_idx_next;
            long_idx_reg  <= long_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // lag table: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (fill_wr.en) begin
            table_mem[fill_wr.addr] <= fill_wr.data;
        end else if (draw_write) begin
            table_mem[k_idx] <= sum;
        end
        rd_j_reg <= table_mem[j_idx];
        rd_k_reg <= table_mem[k_idx];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, value_reg};

    // long index always leads the short one by 31 places around the 54-entry ring
    a_lag_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (long_idx_reg == short_idx_reg + IW'(31)) ||
        (short_idx_reg == long_idx_reg + IW'(23)))
        else $error("lag indices out of step");

    // a pending value that is not taken holds the add step
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == alfg_pkg::S_ADD && out_valid_reg && !m_tready)
        |=> (state_reg == alfg_pkg::S_ADD))
        else $error("draw completed over an untaken value");

    // the expander writes only while the sequencer waits for it
    a_fill_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_wr.en |-> (state_reg == alfg_pkg::S_FILL))
        else $error("table fill outside the fill state");

    // end of fill returns to idle
    a_fill_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_done |=> (state_reg == alfg_pkg::S_IDLE) && !fill_wr.en)
        else $error("fill did not finish cleanly");

endmodule
